// ----- rtl/tcqa_pkg.sv -----
// ----------------------------------------------------------------------------
// tcqa_pkg
// Shared constants, codes and types of the two-class queue arbiter.
// ----------------------------------------------------------------------------
package tcqa_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
    localparam int LIMIT_BITS  = 5;
    localparam int SUM_BITS    = CNT_BITS + 1;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(5);

    typedef enum logic [1:0] {
        CMD_SERVE         = 2'd0,
        CMD_ADD_PRI_TAIL  = 2'd1,
        CMD_ADD_PRI_HEAD  = 2'd2,
        CMD_ADD_NORM_TAIL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_DROPPED = 2'd1,
        ST_SERVED  = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic {
        CLASS_PRIORITY = 1'b0,
        CLASS_NORMAL   = 1'b1
    } class_t;

    // one access per queue memory for each transaction
    typedef struct packed {
        logic                pri_we;
        logic                pri_re;
        logic [IDX_BITS-1:0] pri_addr;
        logic                norm_we;
        logic                norm_re;
        logic [IDX_BITS-1:0] norm_addr;
    } mem_op_t;

    // result fields known at accept time; the served id follows from memory
    typedef struct packed {
        status_t             status;
        class_t              served_class;
        logic [CNT_BITS-1:0] pri_count;
        logic [CNT_BITS-1:0] norm_count;
    } step_res_t;

endpackage

// ----- rtl/tcqa_ram.sv -----
// ----------------------------------------------------------------------------
// tcqa_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module tcqa_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write or read one entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tcqa_sched.sv -----
// ----------------------------------------------------------------------------
// tcqa_sched
// Head pointers and fill counts of both queues; decides each command and
// issues the matching queue memory access.
// ----------------------------------------------------------------------------
module tcqa_sched (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  tcqa_pkg::cmd_t                      command,
    input  logic [tcqa_pkg::LIMIT_BITS-1:0]     limit,
    output tcqa_pkg::mem_op_t                   mem_op,
    output tcqa_pkg::step_res_t                 res
);

    localparam int IW = tcqa_pkg::IDX_BITS;
    localparam int CW = tcqa_pkg::CNT_BITS;
    localparam int SW = tcqa_pkg::SUM_BITS;

    logic [IW-1:0] pri_head_reg,  pri_head_next;
    logic [CW-1:0] pri_used_reg,  pri_used_next;
    logic [IW-1:0] norm_head_reg, norm_head_next;
    logic [CW-1:0] norm_used_reg, norm_used_next;

    logic          pri_full, norm_full, pri_ok, norm_ok;
    logic [IW-1:0] pri_tail, norm_tail, pri_head_dec, pri_head_inc, norm_head_inc;
    logic [SW-1:0] pri_sum, norm_sum;

    // wrap arithmetic on queue indexes
    always_comb begin
        pri_sum  = SW'(pri_head_reg) + SW'(pri_used_reg);
        norm_sum = SW'(norm_head_reg) + SW'(norm_used_reg);
        pri_tail  = (pri_sum >= SW'(tcqa_pkg::QUEUE_DEPTH))
                  ? IW'(pri_sum - SW'(tcqa_pkg::QUEUE_DEPTH)) : IW'(pri_sum);
        norm_tail = (norm_sum >= SW'(tcqa_pkg::QUEUE_DEPTH))
                  ? IW'(norm_sum - SW'(tcqa_pkg::QUEUE_DEPTH)) : IW'(norm_sum);
        pri_head_dec  = (pri_head_reg == '0)
                      ? IW'(tcqa_pkg::QUEUE_DEPTH - 1) : pri_head_reg - IW'(1);
        pri_head_inc  = (pri_head_reg == IW'(tcqa_pkg::QUEUE_DEPTH - 1))
                      ? '0 : pri_head_reg + IW'(1);
        norm_head_inc = (norm_head_reg == IW'(tcqa_pkg::QUEUE_DEPTH - 1))
                      ? '0 : norm_head_reg + IW'(1);
    end

    assign pri_full  = (pri_used_reg == CW'(tcqa_pkg::QUEUE_DEPTH));
    assign norm_full = (norm_used_reg == CW'(tcqa_pkg::QUEUE_DEPTH));
    // priority wins only while the normal backlog is below the limit
    assign pri_ok    = (pri_used_reg != '0) && (SW'(norm_used_reg) < SW'(limit));
    assign norm_ok   = (norm_used_reg != '0);

    // decide the command
    always_comb begin
        pri_head_next  = pri_head_reg;
        pri_used_next  = pri_used_reg;
        norm_head_next = norm_head_reg;
        norm_used_next = norm_used_reg;
        mem_op           = '0;
        mem_op.pri_addr  = pri_head_reg;
        mem_op.norm_addr = norm_head_reg;
        res.status       = tcqa_pkg::ST_ADDED;
        res.served_class = tcqa_pkg::CLASS_PRIORITY;
        unique case (command)
            tcqa_pkg::CMD_ADD_PRI_TAIL: begin
                if (pri_full) begin
                    res.status = tcqa_pkg::ST_DROPPED;
                end else begin
                    mem_op.pri_we   = accept;
                    mem_op.pri_addr = pri_tail;
                    pri_used_next   = pri_used_reg + CW'(1);
                end
            end
            tcqa_pkg::CMD_ADD_PRI_HEAD: begin
                if (pri_full) begin
                    res.status = tcqa_pkg::ST_DROPPED;
                end else begin
                    mem_op.pri_we   = accept;
                    mem_op.pri_addr = pri_head_dec;
                    pri_head_next   = pri_head_dec;
                    pri_used_next   = pri_used_reg + CW'(1);
                end
            end
            tcqa_pkg::CMD_ADD_NORM_TAIL: begin
                if (norm_full) begin
                    res.status = tcqa_pkg::ST_DROPPED;
                end else begin
                    mem_op.norm_we   = accept;
                    mem_op.norm_addr = norm_tail;
                    norm_used_next   = norm_used_reg + CW'(1);
                end
            end
            tcqa_pkg::CMD_SERVE: begin
                if (pri_ok) begin
                    res.status    = tcqa_pkg::ST_SERVED;
                    mem_op.pri_re = accept;
                    pri_head_next = pri_head_inc;
                    pri_used_next = pri_used_reg - CW'(1);
                end else if (norm_ok) begin
                    res.status       = tcqa_pkg::ST_SERVED;
                    res.served_class = tcqa_pkg::CLASS_NORMAL;
                    mem_op.norm_re   = accept;
                    norm_head_next   = norm_head_inc;
                    norm_used_next   = norm_used_reg - CW'(1);
                end else begin
                    res.status = tcqa_pkg::ST_EMPTY;
                end
            end
            default: begin
                res.status = tcqa_pkg::ST_EMPTY;
            end
        endcase
        res.pri_count  = pri_used_next;
        res.norm_count = norm_used_next;
    end

    // advance pointers on each accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pri_head_reg  <= '0;
            pri_used_reg  <= '0;
            norm_head_reg <= '0;
            norm_used_reg <= '0;
        end else if (accept) begin
            pri_head_reg  <= pri_head_next;
            pri_used_reg  <= pri_used_next;
            norm_head_reg <= norm_head_next;
            norm_used_reg <= norm_used_next;
        end
    end

endmodule

// ----- rtl/two_class_queue_arbiter.sv -----
// Pipeline: the decision and the queue RAM read are registered in the read
// stage, then the result in the output register, which m_ready may stall.
// Throughput: one command per cycle unless m_ready stalls; each command makes
// one access to one single-port queue RAM; pointers update in the accept cycle.
// Reset: synchronous, active low; clears pointers, counts and handshake state
// and sets the backlog limit to 5. Queue RAM contents are not cleared.
// ----------------------------------------------------------------------------
// two_class_queue_arbiter
// Two circular id queues, priority and normal, with a serve arbiter that
// yields to the normal class once its backlog reaches a programmable limit.
// ----------------------------------------------------------------------------
module two_class_queue_arbiter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcqa_pkg::LIMIT_BITS-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_command,
    input  logic [tcqa_pkg::ID_BITS-1:0]        s_item_id,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic                                m_served_class,
    output logic [tcqa_pkg::ID_BITS-1:0]        m_served_id,
    output logic [tcqa_pkg::CNT_BITS-1:0]       m_priority_count,
    output logic [tcqa_pkg::CNT_BITS-1:0]       m_normal_count
);

    logic [tcqa_pkg::LIMIT_BITS-1:0] limit_reg;
    logic                            accept, out_free, p1_move;
    tcqa_pkg::mem_op_t               mem_op;
    tcqa_pkg::step_res_t             step_res;
    logic [tcqa_pkg::ID_BITS-1:0]    pri_rdata, norm_rdata, served_id;

    logic                            p1_valid_reg;
    tcqa_pkg::step_res_t             p1_res_reg;
    logic                            m_valid_reg;
    tcqa_pkg::step_res_t             m_res_reg;
    logic [tcqa_pkg::ID_BITS-1:0]    m_id_reg;

    // hold the backlog limit
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= tcqa_pkg::LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // handshake: the read stage drains whenever the output register frees up
    assign out_free = !m_valid_reg || m_ready;
    assign p1_move  = p1_valid_reg && out_free;
    assign s_ready  = !p1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    tcqa_sched u_sched (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .command (tcqa_pkg::cmd_t'(s_command)),
        .limit   (limit_reg),
        .mem_op  (mem_op),
        .res     (step_res)
    );

    tcqa_ram #(
        .DEPTH (tcqa_pkg::QUEUE_DEPTH),
        .WIDTH (tcqa_pkg::ID_BITS)
    ) u_pri_ram (
        .aclk  (aclk),
        .we    (mem_op.pri_we),
        .re    (mem_op.pri_re),
        .addr  (mem_op.pri_addr),
        .wdata (s_item_id),
        .rdata (pri_rdata)
    );

    tcqa_ram #(
        .DEPTH (tcqa_pkg::QUEUE_DEPTH),
        .WIDTH (tcqa_pkg::ID_BITS)
    ) u_norm_ram (
        .aclk  (aclk),
        .we    (mem_op.norm_we),
        .re    (mem_op.norm_re),
        .addr  (mem_op.norm_addr),
        .wdata (s_item_id),
        .rdata (norm_rdata)
    );

    // hold the decision while the queue RAM read completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_move) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_res_reg <= step_res;
        end
    end

    // pick the served id; zero unless something was served
    always_comb begin
        served_id = '0;
        if (p1_res_reg.status == tcqa_pkg::ST_SERVED) begin
            served_id = (p1_res_reg.served_class == tcqa_pkg::CLASS_NORMAL)
                      ? norm_rdata : pri_rdata;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_move) begin
            m_res_reg <= p1_res_reg;
            m_id_reg  <= served_id;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_res_reg.status;
    assign m_served_class   = m_res_reg.served_class;
    assign m_served_id      = m_id_reg;
    assign m_priority_count = m_res_reg.pri_count;
    assign m_normal_count   = m_res_reg.norm_count;

endmodule

// ----- verif/tcqa_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tcqa_checker
// Watches the command, result and limit channels of the two-class queue
// arbiter, keeps its own copy of both queues and the backlog limit, and
// compares every result transaction field by field with the predicted one.
// ----------------------------------------------------------------------------
module tcqa_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [tcqa_pkg::LIMIT_BITS-1:0] cfg_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [1:0]                      s_command,
    input  logic [tcqa_pkg::ID_BITS-1:0]    s_item_id,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [1:0]                      m_status,
    input  logic                            m_served_class,
    input  logic [tcqa_pkg::ID_BITS-1:0]    m_served_id,
    input  logic [tcqa_pkg::CNT_BITS-1:0]   m_priority_count,
    input  logic [tcqa_pkg::CNT_BITS-1:0]   m_normal_count,
    output int                              error_count,
    output int                              pending
);

    typedef struct {
        tcqa_pkg::status_t             status;
        tcqa_pkg::class_t              served_class;
        logic [tcqa_pkg::ID_BITS-1:0]  served_id;
        logic [tcqa_pkg::CNT_BITS-1:0] pri_count;
        logic [tcqa_pkg::CNT_BITS-1:0] norm_count;
    } outcome_t;

    // predicted queue contents, pointers and limit
    logic [tcqa_pkg::ID_BITS-1:0]    pri_ids  [tcqa_pkg::QUEUE_DEPTH];
    logic [tcqa_pkg::ID_BITS-1:0]    norm_ids [tcqa_pkg::QUEUE_DEPTH];
    logic [tcqa_pkg::IDX_BITS-1:0]   pri_head;
    logic [tcqa_pkg::IDX_BITS-1:0]   norm_head;
    logic [tcqa_pkg::CNT_BITS-1:0]   pri_used;
    logic [tcqa_pkg::CNT_BITS-1:0]   norm_used;
    logic [tcqa_pkg::LIMIT_BITS-1:0] backlog_limit;

    outcome_t outcome_q [$];

    function automatic logic [tcqa_pkg::IDX_BITS-1:0] slot_after(
        logic [tcqa_pkg::IDX_BITS-1:0] head,
        int offset
    );
        int slot;
        slot = int'(head) + offset;
        if (slot >= tcqa_pkg::QUEUE_DEPTH) begin
            slot -= tcqa_pkg::QUEUE_DEPTH;
        end
        return tcqa_pkg::IDX_BITS'(slot);
    endfunction

    // apply one command to the predicted queues and return its result
    function automatic outcome_t arbitrate(tcqa_pkg::cmd_t cmd,
                                           logic [tcqa_pkg::ID_BITS-1:0] id);
        outcome_t r;
        r.status       = tcqa_pkg::ST_ADDED;
        r.served_class = tcqa_pkg::CLASS_PRIORITY;
        r.served_id    = '0;
        case (cmd)
            tcqa_pkg::CMD_ADD_PRI_TAIL: begin
                if (pri_used >= tcqa_pkg::QUEUE_DEPTH) begin
                    r.status = tcqa_pkg::ST_DROPPED;
                end else begin
                    pri_ids[slot_after(pri_head, int'(pri_used))] = id;
                    pri_used = pri_used + 1'b1;
                end
            end
            tcqa_pkg::CMD_ADD_PRI_HEAD: begin
                if (pri_used >= tcqa_pkg::QUEUE_DEPTH) begin
                    r.status = tcqa_pkg::ST_DROPPED;
                end else begin
                    // step the head back, wrapping below zero
                    pri_head = (pri_head == 0)
                             ? tcqa_pkg::IDX_BITS'(tcqa_pkg::QUEUE_DEPTH - 1)
                             : pri_head - 1'b1;
                    pri_ids[pri_head] = id;
                    pri_used = pri_used + 1'b1;
                end
            end
            tcqa_pkg::CMD_ADD_NORM_TAIL: begin
                if (norm_used >= tcqa_pkg::QUEUE_DEPTH) begin
                    r.status = tcqa_pkg::ST_DROPPED;
                end else begin
                    norm_ids[slot_after(norm_head, int'(norm_used))] = id;
                    norm_used = norm_used + 1'b1;
                end
            end
            default: begin
                // priority wins only while the normal backlog is under the limit
                if (pri_used != 0 && norm_used < backlog_limit) begin
                    r.status    = tcqa_pkg::ST_SERVED;
                    r.served_id = pri_ids[pri_head];
                    pri_head    = slot_after(pri_head, 1);
                    pri_used    = pri_used - 1'b1;
                end else if (norm_used != 0) begin
                    r.status       = tcqa_pkg::ST_SERVED;
                    r.served_class = tcqa_pkg::CLASS_NORMAL;
                    r.served_id    = norm_ids[norm_head];
                    norm_head      = slot_after(norm_head, 1);
                    norm_used      = norm_used - 1'b1;
                end else begin
                    r.status = tcqa_pkg::ST_EMPTY;
                end
            end
        endcase
        r.pri_count  = pri_used;
        r.norm_count = norm_used;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // compare one result transaction against the oldest prediction
    task automatic check_result();
        outcome_t want;
        if (outcome_q.size() == 0) begin
            $display("%0t: result with no command outstanding, expected none, %s %0d id %0d",
                     $time, "actual status", m_status, m_served_id);
            error_count++;
            return;
        end
        want = outcome_q.pop_front();
        compare_field("status", 32'(want.status), 32'(m_status));
        compare_field("served_class", 32'(want.served_class), 32'(m_served_class));
        compare_field("served_id", 32'(want.served_id), 32'(m_served_id));
        compare_field("priority_count", 32'(want.pri_count), 32'(m_priority_count));
        compare_field("normal_count", 32'(want.norm_count), 32'(m_normal_count));
    endtask

    // sample every channel at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            pri_head      = '0;
            norm_head     = '0;
            pri_used      = '0;
            norm_used     = '0;
            backlog_limit = tcqa_pkg::LIMIT_RESET;
            error_count   = 0;
            outcome_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_result();
            end
            if (cfg_valid && cfg_ready) begin
                backlog_limit = cfg_data;
            end
            if (s_valid && s_ready) begin
                outcome_q.push_back(arbitrate(tcqa_pkg::cmd_t'(s_command), s_item_id));
            end
        end
        pending = outcome_q.size();
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the two-class queue arbiter with directed and random commands under
// random back-pressure, steps the backlog limit through its extremes between
// phases, and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module tb;

    localparam int    HALF_PERIOD  = 10;
    localparam int    PHASES       = 8;
    localparam int    PHASE_ITEMS  = 56;
    localparam longint TIMEOUT_NS  = 64'd200_000 * 20;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_valid = 1'b0;
    logic [tcqa_pkg::LIMIT_BITS-1:0] cfg_data  = '0;
    logic                            s_valid   = 1'b0;
    logic [1:0]                      s_command = '0;
    logic [tcqa_pkg::ID_BITS-1:0]    s_item_id = '0;
    logic                            m_ready   = 1'b0;

    logic                            cfg_ready;
    logic                            s_ready;
    logic                            m_valid;
    logic [1:0]                      m_status;
    logic                            m_served_class;
    logic [tcqa_pkg::ID_BITS-1:0]    m_served_id;
    logic [tcqa_pkg::CNT_BITS-1:0]   m_priority_count;
    logic [tcqa_pkg::CNT_BITS-1:0]   m_normal_count;

    int errors;
    int pending;
    int cmds_taken   = 0;
    int results_seen = 0;
    bit quiet        = 1'b0;
    bit send_calm    = 1'b0;

    two_class_queue_arbiter dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_item_id        (s_item_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_served_class   (m_served_class),
        .m_served_id      (m_served_id),
        .m_priority_count (m_priority_count),
        .m_normal_count   (m_normal_count)
    );

    tcqa_checker u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_item_id        (s_item_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_served_class   (m_served_class),
        .m_served_id      (m_served_id),
        .m_priority_count (m_priority_count),
        .m_normal_count   (m_normal_count),
        .error_count      (errors),
        .pending          (pending)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // count transactions on both channels for pacing
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                cmds_taken <= cmds_taken + 1;
            end
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
            end
        end
    end

    // result side: stall in bursts, with calm stretches between
    initial begin : result_sink
        int stall_left;
        int stretch_left;
        int stall_odds;
        stall_left   = 0;
        stretch_left = 0;
        stall_odds   = 0;
        forever begin
            @(posedge aclk);
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(16, 96);
                stall_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 8);
            end
            stretch_left--;
            if (quiet) begin
                stall_left = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!quiet && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                stall_left = $urandom_range(1, 8) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // hold one command until accepted; called and returns at a clock edge
    task automatic send_cmd(input tcqa_pkg::cmd_t cmd,
                            input logic [tcqa_pkg::ID_BITS-1:0] id, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_item_id <= id;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_seen != cmds_taken) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [tcqa_pkg::LIMIT_BITS-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_gap();
        if (quiet || send_calm) begin
            return 0;
        end
        return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
    endfunction

    function automatic logic [tcqa_pkg::ID_BITS-1:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 1) begin
            return '1;
        end
        return tcqa_pkg::ID_BITS'($urandom_range(0, 255));
    endfunction

    // mode 0 fills, 1 drains, 2 mixes evenly, 3 leans on the normal class
    function automatic tcqa_pkg::cmd_t pick_cmd(input int mode);
        int r;
        int serve_pct;
        r = $urandom_range(0, 99);
        case (mode)
            0: serve_pct = 10;
            1: serve_pct = 75;
            2: serve_pct = 25;
            default: serve_pct = 30;
        endcase
        if (r < serve_pct) begin
            return tcqa_pkg::CMD_SERVE;
        end
        r = $urandom_range(0, 99);
        if (mode == 3) begin
            return (r < 70) ? tcqa_pkg::CMD_ADD_NORM_TAIL
                 : (r < 85) ? tcqa_pkg::CMD_ADD_PRI_TAIL : tcqa_pkg::CMD_ADD_PRI_HEAD;
        end
        return (r < 34) ? tcqa_pkg::CMD_ADD_NORM_TAIL
             : (r < 67) ? tcqa_pkg::CMD_ADD_PRI_TAIL : tcqa_pkg::CMD_ADD_PRI_HEAD;
    endfunction

    initial begin : stimulus
        logic [tcqa_pkg::LIMIT_BITS-1:0] limits [PHASES];
        int mode;
        int mode_left;
        limits    = '{5'd0, 5'd31, 5'd16, 5'd17, 5'd1, 5'd5, 5'd0, 5'd8};
        limits[6] = tcqa_pkg::LIMIT_BITS'($urandom_range(0, 31));
        mode      = 0;
        mode_left = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // serve on empty, both id extremes, urgent add wrapping the head
        send_cmd(tcqa_pkg::CMD_SERVE, 8'h00, 0);
        send_cmd(tcqa_pkg::CMD_ADD_PRI_TAIL, 8'h00, 0);
        send_cmd(tcqa_pkg::CMD_ADD_PRI_TAIL, 8'hFF, 0);
        send_cmd(tcqa_pkg::CMD_ADD_PRI_HEAD, 8'hA5, 0);
        send_cmd(tcqa_pkg::CMD_ADD_NORM_TAIL, 8'h5A, 0);
        send_cmd(tcqa_pkg::CMD_ADD_NORM_TAIL, 8'hFF, 0);
        repeat (6) send_cmd(tcqa_pkg::CMD_SERVE, 8'hFF, 0);

        // normal backlog at the reset limit hands the serve to the normal class
        send_cmd(tcqa_pkg::CMD_ADD_NORM_TAIL, 8'h01, 0);
        send_cmd(tcqa_pkg::CMD_ADD_NORM_TAIL, 8'h02, 0);
        send_cmd(tcqa_pkg::CMD_ADD_NORM_TAIL, 8'h04, 0);
        send_cmd(tcqa_pkg::CMD_ADD_NORM_TAIL, 8'h08, 0);
        send_cmd(tcqa_pkg::CMD_ADD_NORM_TAIL, 8'h10, 0);
        send_cmd(tcqa_pkg::CMD_ADD_PRI_TAIL, 8'h20, 0);
        repeat (6) send_cmd(tcqa_pkg::CMD_SERVE, 8'h00, 0);

        // random phases, each under its own limit, last one without idling
        for (int p = 0; p < PHASES; p++) begin
            write_limit(limits[p]);
            if (p == PHASES - 1) begin
                quiet = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 24 == 0) begin
                    send_calm = ($urandom_range(0, 2) == 0);
                end
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 40);
                end
                mode_left--;
                send_cmd(pick_cmd(mode), pick_id(), pick_gap());
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule
